[rtl/dda_pkg.sv]
// Shared constants for the DDA line rasterizer: field widths, register
// indexes, reset values, command codes and queue depth. No dependencies.
`default_nettype none

package dda_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int CFG_W      = 11;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 13;
    localparam int OUT_DATA_W = ((2 * PIX_W + COLOR_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ORIGIN_Y = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] ORIGIN_X_RST = 11'd500;
    localparam logic [CFG_W-1:0] ORIGIN_Y_RST = 11'd300;

    // Command codes carried in tuser.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Depth of the command queue between front and back (power of two).
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[rtl/dda_front.sv]
// Input side of the rasterizer: accepts commands, computes the line deltas
// and step count for start commands, and buffers them in a short queue.
// Depends on dda_pkg.
`default_nettype none

module dda_front #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire                                            i_valid,
    output logic                                           o_ready,
    input  wire [((4*COORD_BITS+dda_pkg::COLOR_W+7)/8)*8-1:0] i_data,
    input  wire                                            i_func,
    output logic                                           o_head_valid,
    input  wire                                            i_pop,
    output logic                                           o_head_func,
    output logic [COORD_BITS-1:0]                          o_head_xs,
    output logic [COORD_BITS-1:0]                          o_head_ys,
    output logic                                           o_head_dx_neg,
    output logic [COORD_BITS:0]                            o_head_dx_mag,
    output logic                                           o_head_dy_neg,
    output logic [COORD_BITS:0]                            o_head_dy_mag,
    output logic [COORD_BITS:0]                            o_head_steps,
    output logic [dda_pkg::COLOR_W-1:0]                    o_head_color
);
    import dda_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [COLOR_W-1:0]    color;
    logic [DW-1:0]         dx, dy, dx_mag, dy_mag, steps;
    logic                  push;

    logic                  r_func   [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] r_xs     [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] r_ys     [QUEUE_DEPTH];
    logic                  r_dx_neg [QUEUE_DEPTH];
    logic [DW-1:0]         r_dx_mag [QUEUE_DEPTH];
    logic                  r_dy_neg [QUEUE_DEPTH];
    logic [DW-1:0]         r_dy_mag [QUEUE_DEPTH];
    logic [DW-1:0]         r_steps  [QUEUE_DEPTH];
    logic [COLOR_W-1:0]    r_color  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    // Unpack the endpoints and color from the transfer.
    assign xs    = i_data[COORD_BITS-1:0];
    assign ys    = i_data[2*COORD_BITS-1:COORD_BITS];
    assign xe    = i_data[3*COORD_BITS-1:2*COORD_BITS];
    assign ye    = i_data[4*COORD_BITS-1:3*COORD_BITS];
    assign color = i_data[4*COORD_BITS+COLOR_W-1:4*COORD_BITS];

    // Signed deltas, their magnitudes and the step count (larger magnitude).
    always_comb begin
        dx     = {xe[COORD_BITS-1], xe} - {xs[COORD_BITS-1], xs};
        dy     = {ye[COORD_BITS-1], ye} - {ys[COORD_BITS-1], ys};
        dx_mag = dx[DW-1] ? -dx : dx;
        dy_mag = dy[DW-1] ? -dy : dy;
        steps  = (dx_mag > dy_mag) ? dx_mag : dy_mag;
    end

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;

    // Queue storage: written at the tail, no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_func[r_wr_ptr]   <= i_func;
            r_xs[r_wr_ptr]     <= xs;
            r_ys[r_wr_ptr]     <= ys;
            r_dx_neg[r_wr_ptr] <= dx[DW-1];
            r_dx_mag[r_wr_ptr] <= dx_mag;
            r_dy_neg[r_wr_ptr] <= dy[DW-1];
            r_dy_mag[r_wr_ptr] <= dy_mag;
            r_steps[r_wr_ptr]  <= steps;
            r_color[r_wr_ptr]  <= color;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Head of the queue, seen by the back end.
    assign o_head_valid  = (r_count != '0);
    assign o_head_func   = r_func[r_rd_ptr];
    assign o_head_xs     = r_xs[r_rd_ptr];
    assign o_head_ys     = r_ys[r_rd_ptr];
    assign o_head_dx_neg = r_dx_neg[r_rd_ptr];
    assign o_head_dx_mag = r_dx_mag[r_rd_ptr];
    assign o_head_dy_neg = r_dy_neg[r_rd_ptr];
    assign o_head_dy_mag = r_dy_mag[r_rd_ptr];
    assign o_head_steps  = r_steps[r_rd_ptr];
    assign o_head_color  = r_color[r_rd_ptr];

endmodule

`default_nettype wire

[rtl/dda_div.sv]
// Bit-serial restoring divider that forms round(mag * 2^FRAC_BITS / steps)
// with ties away from zero, one quotient bit per cycle. Depends on dda_pkg.
`default_nettype none

module dda_div #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [COORD_BITS:0]    i_mag,
    input  wire [COORD_BITS:0]    i_divisor,
    output logic                  o_done,
    output logic [FRAC_BITS+1:0]  o_quot
);
    import dda_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int NUM_W = DW + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] numer;
    logic [DW:0]      shifted;
    logic [DW+1:0]    diff;

    logic [NUM_W-1:0] r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // Scaled dividend with half the divisor added for rounding.
    assign numer = NUM_W'({i_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(i_divisor >> 1);

    // One restoring step: bring down the next dividend bit and trial-subtract.
    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
    end

    // Payload registers: dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= numer;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ~diff[DW+1]};
            r_rem <= diff[DW+1] ? shifted[DW-1:0] : diff[DW-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient never exceeds 2^FRAC_BITS, so the low bits hold it whole.
    assign o_done = r_done;
    assign o_quot = r_num[FRAC_BITS+1:0];

endmodule

`default_nettype wire

[rtl/dda_back.sv]
// Execution side of the rasterizer: sets up a line through the shared
// divider, steps the fixed-point position and drives the pixel output
// register. Depends on dda_pkg and dda_div.
`default_nettype none

module dda_back #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [dda_pkg::CFG_W-1:0]   i_origin_x,
    input  wire [dda_pkg::CFG_W-1:0]   i_origin_y,
    input  wire                        i_head_valid,
    output logic                       o_pop,
    input  wire                        i_head_func,
    input  wire [COORD_BITS-1:0]       i_head_xs,
    input  wire [COORD_BITS-1:0]       i_head_ys,
    input  wire                        i_head_dx_neg,
    input  wire [COORD_BITS:0]         i_head_dx_mag,
    input  wire                        i_head_dy_neg,
    input  wire [COORD_BITS:0]         i_head_dy_mag,
    input  wire [COORD_BITS:0]         i_head_steps,
    input  wire [dda_pkg::COLOR_W-1:0] i_head_color,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [dda_pkg::PIX_W-1:0]  o_pixel_x,
    output logic [dda_pkg::PIX_W-1:0]  o_pixel_y,
    output logic [dda_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                       o_last_pixel
);
    import dda_pkg::*;

    localparam int DW     = COORD_BITS + 1;
    localparam int POS_IW = COORD_BITS + 1;
    localparam int POS_W  = POS_IW + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int SUM_W  = ((POS_IW > PIX_W) ? POS_IW : PIX_W) + 1;

    // Sequencer codes.
    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_DIVX = 2'd1;
    localparam logic [1:0] S_DIVY = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [POS_W-1:0]   r_pos_x, r_pos_y;
    logic [STEP_W-1:0]  r_step_x, r_step_y;
    logic [DW-1:0]      r_left;
    logic [COLOR_W-1:0] r_color;
    logic               r_dx_neg, r_dy_neg;
    logic [DW-1:0]      r_dy_mag, r_steps;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pix_x, r_pix_y;
    logic [COLOR_W-1:0] r_pix_color;
    logic               r_last;

    logic               out_free;
    logic               take_start, take_pixel;
    logic               div_start, div_done;
    logic [DW-1:0]      div_mag, div_divisor;
    logic [STEP_W-1:0]  quot, step_signed;
    logic [POS_IW-1:0]  floor_x, floor_y;
    logic [SUM_W-1:0]   sum_x, sum_y;

    assign out_free = !r_out_valid || i_out_ready;

    // Decide what the head command does this cycle.
    always_comb begin
        take_start = 1'b0;
        take_pixel = 1'b0;
        o_pop      = 1'b0;
        if (r_state == S_RUN && i_head_valid) begin
            if (i_head_func == FUNC_START) begin
                take_start = 1'b1;
                o_pop      = 1'b1;
            end else if (r_left == '0) begin
                o_pop = 1'b1;
            end else if (out_free) begin
                take_pixel = 1'b1;
                o_pop      = 1'b1;
            end
        end
    end

    // Divider request: x increment from the queue head, y from held operands.
    always_comb begin
        div_start   = 1'b0;
        div_mag     = i_head_dx_mag;
        div_divisor = i_head_steps;
        if (take_start && i_head_steps != '0) begin
            div_start = 1'b1;
        end else if (r_state == S_DIVX && div_done) begin
            div_start   = 1'b1;
            div_mag     = r_dy_mag;
            div_divisor = r_steps;
        end
    end

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (div_mag),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    // Apply the sign of the delta to the increment magnitude.
    always_comb begin
        if (r_state == S_DIVX) begin
            step_signed = r_dx_neg ? -quot : quot;
        end else begin
            step_signed = r_dy_neg ? -quot : quot;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (div_start) begin
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // Screen coordinates: origin plus or minus the integer part of the position.
    always_comb begin
        floor_x = r_pos_x[POS_W-1:FRAC_BITS];
        floor_y = r_pos_y[POS_W-1:FRAC_BITS];
        sum_x   = {{(SUM_W-CFG_W){1'b0}}, i_origin_x}
                + {{(SUM_W-POS_IW){floor_x[POS_IW-1]}}, floor_x};
        sum_y   = {{(SUM_W-CFG_W){1'b0}}, i_origin_y}
                - {{(SUM_W-POS_IW){floor_y[POS_IW-1]}}, floor_y};
    end

    // Control state: sequencer, pixel count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_start) begin
                r_left <= i_head_steps;
            end else if (take_pixel) begin
                r_left <= r_left - 1'b1;
            end
            if (take_pixel) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line state: position, increments, color and divider operands.
    always_ff @(posedge i_clk) begin
        if (take_start) begin
            r_pos_x  <= {{(POS_IW-COORD_BITS){i_head_xs[COORD_BITS-1]}}, i_head_xs,
                         {FRAC_BITS{1'b0}}};
            r_pos_y  <= {{(POS_IW-COORD_BITS){i_head_ys[COORD_BITS-1]}}, i_head_ys,
                         {FRAC_BITS{1'b0}}};
            r_color  <= i_head_color;
            r_dx_neg <= i_head_dx_neg;
            r_dy_neg <= i_head_dy_neg;
            r_dy_mag <= i_head_dy_mag;
            r_steps  <= i_head_steps;
            r_step_x <= '0;
            r_step_y <= '0;
        end else if (take_pixel) begin
            r_pos_x <= r_pos_x + {{(POS_W-STEP_W){r_step_x[STEP_W-1]}}, r_step_x};
            r_pos_y <= r_pos_y + {{(POS_W-STEP_W){r_step_y[STEP_W-1]}}, r_step_y};
        end
        if (div_done && r_state == S_DIVX) begin
            r_step_x <= step_signed;
        end
        if (div_done && r_state == S_DIVY) begin
            r_step_y <= step_signed;
        end
    end

    // Output register, loaded whenever a pixel is emitted.
    always_ff @(posedge i_clk) begin
        if (take_pixel) begin
            r_pix_x     <= sum_x[PIX_W-1:0];
            r_pix_y     <= sum_y[PIX_W-1:0];
            r_pix_color <= r_color;
            r_last      <= (r_left == DW'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_pixel_color = r_pix_color;
    assign o_last_pixel  = r_last;

endmodule

`default_nettype wire

[rtl/dda_line_rasterizer_core.sv]
// DDA line rasterizer. A start command (tuser 0) loads two endpoints and a
// color; each pixel command (tuser 1) then returns the next pixel of the line
// until steps = max(|dx|, |dy|) pixels have gone out, the end point excluded,
// and tlast marks the final one. Pixel commands stream at one per cycle while
// the pixel output is not stalled. A start command with a nonzero length
// holds the back end while one bit-serial divider forms the x and then the y
// increment; a two-entry command queue keeps accepting input meanwhile until
// it is full. Pixel commands with no line active are consumed without output.
// Coordinates are not clipped. Depends on dda_pkg, dda_front, dda_back.
`default_nettype none

module dda_line_rasterizer_core #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  wire                                             i_clk,
    input  wire                                             i_rst_n,
    // Command stream.
    input  wire                                             i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    // tdata from bit 0: x_start, y_start, x_end, y_end, line_color, zero pad.
    input  wire [((4*COORD_BITS+dda_pkg::COLOR_W+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: func.
    input  wire                                             i_s_axis_tuser,
    // Pixel stream.
    output logic                                            o_m_axis_tvalid,
    input  wire                                             i_m_axis_tready,
    // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero pad.
    output logic [dda_pkg::OUT_DATA_W-1:0]                  o_m_axis_tdata,
    // tlast: last_pixel.
    output logic                                            o_m_axis_tlast,
    // Configuration writes.
    input  wire                                             i_cfg_wr_en,
    input  wire [dda_pkg::CFG_IDX_W-1:0]                    i_cfg_index,
    input  wire [dda_pkg::CFG_W-1:0]                        i_cfg_data
);
    import dda_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int PAD_W = OUT_DATA_W - 2 * PIX_W - COLOR_W;

    logic [CFG_W-1:0]      r_origin_x, r_origin_y;

    logic                  head_valid, pop, head_func;
    logic [COORD_BITS-1:0] head_xs, head_ys;
    logic                  head_dx_neg, head_dy_neg;
    logic [DW-1:0]         head_dx_mag, head_dy_mag, head_steps;
    logic [COLOR_W-1:0]    head_color;
    logic [PIX_W-1:0]      pixel_x, pixel_y;
    logic [COLOR_W-1:0]    pixel_color;

    // Origin registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_X_RST;
            r_origin_y <= ORIGIN_Y_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDX_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_IDX_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_data        (i_s_axis_tdata),
        .i_func        (i_s_axis_tuser),
        .o_head_valid  (head_valid),
        .i_pop         (pop),
        .o_head_func   (head_func),
        .o_head_xs     (head_xs),
        .o_head_ys     (head_ys),
        .o_head_dx_neg (head_dx_neg),
        .o_head_dx_mag (head_dx_mag),
        .o_head_dy_neg (head_dy_neg),
        .o_head_dy_mag (head_dy_mag),
        .o_head_steps  (head_steps),
        .o_head_color  (head_color)
    );

    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_origin_x     (r_origin_x),
        .i_origin_y     (r_origin_y),
        .i_head_valid   (head_valid),
        .o_pop          (pop),
        .i_head_func    (head_func),
        .i_head_xs      (head_xs),
        .i_head_ys      (head_ys),
        .i_head_dx_neg  (head_dx_neg),
        .i_head_dx_mag  (head_dx_mag),
        .i_head_dy_neg  (head_dy_neg),
        .i_head_dy_mag  (head_dy_mag),
        .i_head_steps   (head_steps),
        .i_head_color   (head_color),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_pixel_color  (pixel_color),
        .o_last_pixel   (o_m_axis_tlast)
    );

    // Pack the pixel transfer.
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, pixel_color, pixel_y, pixel_x};

endmodule

`default_nettype wire

[rtl/dda_checker.sv]
// Port-level checks for the DDA line rasterizer, bound to the top level.
// Depends on dda_pkg and dda_line_rasterizer_core.
`default_nettype none

module dda_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_axis_tvalid,
    input wire                             o_s_axis_tready,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    input wire [dda_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input wire                             o_m_axis_tlast
);

    // A stalled pixel transfer keeps its valid and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("pixel output changed while stalled");

    // Reset empties the output register.
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("pixel output valid right after reset");

    // Reset empties the command queue, so commands are taken at once.
    a_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("command input not ready right after reset");

    // The queue only fills up through a command transfer.
    a_full_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(i_s_axis_tvalid))
        else $error("command queue filled without a transfer");

endmodule

bind dda_line_rasterizer_core dda_checker u_dda_checker (.*);

`default_nettype wire
